/* rtl/core/ctt_pkg.sv */
// Shared constants, codes and control types for the conveyor task tracker.
// No dependencies; every other file of the block imports this package.
package ctt_pkg;

  localparam int TASK_SLOTS   = 16;
  localparam int IDX_W        = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W        = $clog2(TASK_SLOTS + 1);

  localparam int TARGET_W     = 24;
  localparam int VALVE_W      = 8;
  localparam int MASK_W       = 16;
  localparam int SPEED_W      = 18;
  localparam int MS_W         = 16;
  localparam int ID_W         = 16;
  localparam int KIND_W       = 2;
  localparam int DIST_W       = 32;
  localparam int DS_W         = SPEED_W + 1 + MS_W;

  // Distances are kept in 1/120 micrometre.
  localparam logic [DIST_W-1:0] UNITS_PER_UM = DIST_W'(120);

  // Input item kinds.
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_SPEED = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    RES_ACCEPTED = 2'd0,
    RES_FIRE     = 2'd1,
    RES_FULL     = 2'd2
  } result_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_MUL,
    ST_SCAN,
    ST_FINISH
  } ctt_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic do_add;
    logic do_mul;
    logic scan_step;
    logic finish;
  } ctt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_acc;
    logic in_is_add;
    logic in_ms_zero;
    logic scan_done;
    logic slot_fire;
    logic pend_valid;
    logic out_blocked;
  } ctt_sts_t;

endpackage

/* rtl/core/ctt_in_if.sv */
// Input channel of the conveyor task tracker: valid/ready plus one item.
// Depends on ctt_pkg for field widths.
interface ctt_in_if
  import ctt_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [TARGET_W-1:0] target_um;
  logic [VALVE_W-1:0]  valve_id;
  logic [MASK_W-1:0]   valve_mask;
  logic [SPEED_W-1:0]  speed_mm_per_min;
  logic [MS_W-1:0]     elapsed_ms;

  modport source (output valid, kind, target_um, valve_id, valve_mask,
                  speed_mm_per_min, elapsed_ms, input ready);
  modport sink   (input valid, kind, target_um, valve_id, valve_mask,
                  speed_mm_per_min, elapsed_ms, output ready);
endinterface

/* rtl/core/ctt_out_if.sv */
// Result channel of the conveyor task tracker: valid/ready plus one item.
// Depends on ctt_pkg for field widths.
interface ctt_out_if
  import ctt_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  result_kind;
  logic [ID_W-1:0]    task_id;
  logic [VALVE_W-1:0] valve_id_res;
  logic [MASK_W-1:0]  valve_mask_res;
  logic               last;

  modport source (output valid, result_kind, task_id, valve_id_res, valve_mask_res,
                  last, input ready);
  modport sink   (input valid, result_kind, task_id, valve_id_res, valve_mask_res,
                  last, output ready);
endinterface

/* rtl/core/ctt_datapath.sv */
// Task store, distance arithmetic, pending fire and output register.
// Depends on ctt_pkg and the ctt_in_if / ctt_out_if channel interfaces.
module ctt_datapath
  import ctt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ctt_in_if.sink      in_ch,
  ctt_out_if.source   out_ch,
  input  ctt_cmd_t    cmd,
  output ctt_sts_t    sts
);

  // Task store.
  logic [DIST_W-1:0]  tgt_mem   [TASK_SLOTS];
  logic [DIST_W-1:0]  trav_mem  [TASK_SLOTS];
  logic [VALVE_W-1:0] valve_mem [TASK_SLOTS];
  logic [MASK_W-1:0]  mask_mem  [TASK_SLOTS];
  logic [ID_W-1:0]    id_mem    [TASK_SLOTS];

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ID_W-1:0]     next_id_r, next_id_nxt;
  logic [SPEED_W-1:0]  prev_speed_r, prev_speed_nxt;
  logic [CNT_W-1:0]    rd_r, rd_nxt;
  logic [CNT_W-1:0]    keep_r, keep_nxt;
  logic [DS_W-1:0]     ds_r, ds_nxt;

  // Latched input item.
  logic [TARGET_W-1:0] lat_target_r;
  logic [VALVE_W-1:0]  lat_valve_r;
  logic [MASK_W-1:0]   lat_mask_r;
  logic [SPEED_W-1:0]  lat_speed_r;
  logic [MS_W-1:0]     lat_ms_r;

  // Fire result held until it is known whether it is the last one.
  logic                pend_valid_r, pend_valid_nxt;
  logic [ID_W-1:0]     pend_id_r;
  logic [VALVE_W-1:0]  pend_valve_r;
  logic [MASK_W-1:0]   pend_mask_r;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  result_kind_t        out_kind_r;
  logic [ID_W-1:0]     out_id_r;
  logic [VALVE_W-1:0]  out_valve_r;
  logic [MASK_W-1:0]   out_mask_r;
  logic                out_last_r;

  logic                in_acc;
  logic                out_blocked;
  logic                full;
  logic [IDX_W-1:0]    rd_idx;
  logic [DS_W:0]       sum_wide;
  logic [DIST_W-1:0]   sum_sat;
  logic                slot_fire;
  logic [SPEED_W:0]    speed_sum;
  logic                load_out;
  logic                pend_to_out;

  assign in_ch.ready  = cmd.in_ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_blocked  = out_valid_r && !out_ch.ready;
  assign full         = (count_r == CNT_W'(TASK_SLOTS));
  assign rd_idx       = rd_r[IDX_W-1:0];

  assign sum_wide  = (DS_W+1)'(trav_mem[rd_idx]) + (DS_W+1)'(ds_r);
  assign sum_sat   = (|sum_wide[DS_W:DIST_W]) ? '1 : sum_wide[DIST_W-1:0];
  assign slot_fire = (sum_sat >= tgt_mem[rd_idx]);
  assign speed_sum = (SPEED_W+1)'(prev_speed_r) + (SPEED_W+1)'(lat_speed_r);

  assign pend_to_out = (cmd.scan_step && slot_fire && pend_valid_r) ||
                       (cmd.finish && pend_valid_r);
  assign load_out    = cmd.do_add || pend_to_out;

  assign sts.in_acc      = in_acc;
  assign sts.in_is_add   = (in_ch.kind == KIND_ADD);
  assign sts.in_ms_zero  = (in_ch.elapsed_ms == '0);
  assign sts.scan_done   = (rd_r == count_r);
  assign sts.slot_fire   = slot_fire;
  assign sts.pend_valid  = pend_valid_r;
  assign sts.out_blocked = out_blocked;

  always_comb begin
    count_nxt      = count_r;
    next_id_nxt    = next_id_r;
    prev_speed_nxt = prev_speed_r;
    rd_nxt         = rd_r;
    keep_nxt       = keep_r;
    ds_nxt         = ds_r;
    pend_valid_nxt = pend_valid_r;
    if (cmd.do_add && !full) begin
      count_nxt   = count_r + CNT_W'(1);
      next_id_nxt = next_id_r + ID_W'(1);
    end
    if (cmd.do_mul) begin
      ds_nxt         = DS_W'(speed_sum) * DS_W'(lat_ms_r);
      prev_speed_nxt = lat_speed_r;
      rd_nxt         = '0;
      keep_nxt       = '0;
      pend_valid_nxt = 1'b0;
    end
    if (cmd.scan_step) begin
      rd_nxt = rd_r + CNT_W'(1);
      if (slot_fire) begin
        pend_valid_nxt = 1'b1;
      end else begin
        keep_nxt = keep_r + CNT_W'(1);
      end
    end
    if (cmd.finish) begin
      count_nxt      = keep_r;
      pend_valid_nxt = 1'b0;
    end
    out_valid_nxt = load_out ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      next_id_r    <= '0;
      prev_speed_r <= '0;
      rd_r         <= '0;
      keep_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      next_id_r    <= next_id_nxt;
      prev_speed_r <= prev_speed_nxt;
      rd_r         <= rd_nxt;
      keep_r       <= keep_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ds_r <= ds_nxt;
    if (in_acc) begin
      lat_target_r <= in_ch.target_um;
      lat_valve_r  <= in_ch.valve_id;
      lat_mask_r   <= in_ch.valve_mask;
      lat_speed_r  <= in_ch.speed_mm_per_min;
      lat_ms_r     <= in_ch.elapsed_ms;
    end
    if (cmd.scan_step && slot_fire) begin
      pend_id_r    <= id_mem[rd_idx];
      pend_valve_r <= valve_mem[rd_idx];
      pend_mask_r  <= mask_mem[rd_idx];
    end
    if (cmd.do_add) begin
      out_kind_r  <= full ? RES_FULL : RES_ACCEPTED;
      out_id_r    <= full ? '0 : next_id_r;
      out_valve_r <= '0;
      out_mask_r  <= '0;
      out_last_r  <= 1'b1;
    end else if (pend_to_out) begin
      out_kind_r  <= RES_FIRE;
      out_id_r    <= pend_id_r;
      out_valve_r <= pend_valve_r;
      out_mask_r  <= pend_mask_r;
      out_last_r  <= cmd.finish;
    end
  end

  // Store writes: append on add, compaction write during the scan.
  always_ff @(posedge clk) begin
    if (cmd.do_add && !full) begin
      tgt_mem[count_r[IDX_W-1:0]]   <= DIST_W'(lat_target_r) * UNITS_PER_UM;
      trav_mem[count_r[IDX_W-1:0]]  <= '0;
      valve_mem[count_r[IDX_W-1:0]] <= lat_valve_r;
      mask_mem[count_r[IDX_W-1:0]]  <= lat_mask_r;
      id_mem[count_r[IDX_W-1:0]]    <= next_id_r;
    end else if (cmd.scan_step && !slot_fire) begin
      tgt_mem[keep_r[IDX_W-1:0]]   <= tgt_mem[rd_idx];
      trav_mem[keep_r[IDX_W-1:0]]  <= sum_sat;
      valve_mem[keep_r[IDX_W-1:0]] <= valve_mem[rd_idx];
      mask_mem[keep_r[IDX_W-1:0]]  <= mask_mem[rd_idx];
      id_mem[keep_r[IDX_W-1:0]]    <= id_mem[rd_idx];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_kind    = out_kind_r;
  assign out_ch.task_id        = out_id_r;
  assign out_ch.valve_id_res   = out_valve_r;
  assign out_ch.valve_mask_res = out_mask_r;
  assign out_ch.last           = out_last_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TASK_SLOTS))
    else $error("task count above slot count");

  a_keep_behind: assert property (@(posedge clk) disable iff (!rst_n)
    keep_r <= rd_r)
    else $error("compaction index ahead of scan index");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> !out_blocked)
    else $error("output register loaded while a result is still waiting");

  a_finish_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> count_r == $past(keep_r))
    else $error("task count not taken from kept tasks after a scan");

endmodule

/* rtl/core/ctt_ctrl.sv */
// Sequencing state machine of the conveyor task tracker.
// Depends on ctt_pkg for the state type and the command/status structs.
module ctt_ctrl
  import ctt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  ctt_sts_t sts,
  output ctt_cmd_t cmd
);

  ctt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_acc) begin
          if (sts.in_is_add) begin
            state_nxt = ST_ADD;
          end else if (!sts.in_ms_zero) begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_ADD: begin
        if (!sts.out_blocked) begin
          cmd.do_add = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd.do_mul = 1'b1;
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        // A second fire needs the held one moved out first.
        if (sts.scan_done) begin
          state_nxt = ST_FINISH;
        end else if (!(sts.slot_fire && sts.pend_valid && sts.out_blocked)) begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!(sts.pend_valid && sts.out_blocked)) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/conveyor_distance_task_tracker_unit.sv */
// Top level of the conveyor task tracker: controller plus datapath.
// Depends on ctt_pkg, ctt_in_if, ctt_out_if, ctt_ctrl and ctt_datapath.
//
// The block keeps an ordered list of up to TASK_SLOTS ejector tasks. An item on
// in_ch either adds a task (kind 0) or reports belt speed and elapsed time
// (kind 1). Results leave on out_ch, one item per result, with last set on
// the final result that an input item causes.
// An add item's single result (accepted with its id, or table full) enters
// the output register on the next cycle, or as soon as that register is
// free; the next item can be taken the cycle after.
// A speed item with zero elapsed time causes nothing and the block is ready
// again on the next cycle. Any other speed item runs the distance multiply,
// then a walk over the stored tasks that adds distance, fires and compacts,
// then a step that sees the walk end and a closing step, and only then can
// the next item be taken. Fired tasks come out in list order. One fire
// result is held inside while the next one is looked for, so when the
// receiver stalls the walk pauses at the next firing task and resumes when
// the output register drains. A new item is accepted only between items,
// even while a result still waits in the output register. Reset empties
// the list, zeroes the id counter and the remembered speed.
module conveyor_distance_task_tracker_unit
  import ctt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ctt_in_if.sink    in_ch,
  ctt_out_if.source out_ch
);

  ctt_cmd_t cmd;
  ctt_sts_t sts;

  // The controller only sequences; all storage and arithmetic sit in the
  // datapath, which also owns both channel handshakes.
  ctt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  ctt_datapath u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

/* test/testbench.sv */
// Self-checking testbench for the conveyor task tracker: an in-bench predictor
// of the task list, random pacing on both channels and a long output stall.
// Depends on ctt_pkg, ctt_in_if, ctt_out_if and conveyor_distance_task_tracker_unit.
`timescale 1ns / 1ps

module testbench
  import ctt_pkg::*;
;

  // Generous bound on the whole run, far above what the items need even when
  // every result is held off by the longest receiver stalls.
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int DRAIN_LIMIT   = 50_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 250;
  localparam int RANDOM_ITEMS  = 180;
  localparam int PRINT_LIMIT   = 40;

  // One input item as the sender offers it.
  typedef struct packed {
    logic                kind;
    logic [TARGET_W-1:0] target_um;
    logic [VALVE_W-1:0]  valve_id;
    logic [MASK_W-1:0]   valve_mask;
    logic [SPEED_W-1:0]  speed_mm_per_min;
    logic [MS_W-1:0]     elapsed_ms;
  } belt_item_t;

  // One result item as the block should deliver it.
  typedef struct packed {
    result_kind_t        kind;
    logic [ID_W-1:0]     id;
    logic [VALVE_W-1:0]  valve;
    logic [MASK_W-1:0]   mask;
    logic                last;
  } tracker_result_t;

  logic clk;
  logic rst_n;

  ctt_in_if  in_ch ();
  ctt_out_if out_ch ();

  conveyor_distance_task_tracker_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted copy of the task list. Only entries below slot_used are read.
  logic [DIST_W-1:0]  slot_goal  [TASK_SLOTS];
  logic [DIST_W-1:0]  slot_moved [TASK_SLOTS];
  logic [VALVE_W-1:0] slot_valve [TASK_SLOTS];
  logic [MASK_W-1:0]  slot_mask  [TASK_SLOTS];
  logic [ID_W-1:0]    slot_tag   [TASK_SLOTS];
  int                 slot_used;
  logic [ID_W-1:0]    id_counter;
  logic [SPEED_W-1:0] last_speed;

  // Results still owed by the block, oldest first.
  tracker_result_t pending_results [$];

  int  mismatch_count;
  int  items_sent;
  int  results_seen;
  int  fires_seen;
  int  full_seen;
  int  cycle_count;
  int  hold_request;
  bit  pacing_on;

  // Clock: 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Prints one line per mismatch; after PRINT_LIMIT lines it only counts, so a
  // broken id counter cannot flood the log.
  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                                results_seen, name, got, want));
    end
  endtask

  // Random gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!pacing_on || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Predictor. Called once for every accepted input item; it updates the
  // predicted task list and queues whatever results the item must produce.
  task automatic predict_item(input belt_item_t it);
    tracker_result_t res;
    tracker_result_t burst [TASK_SLOTS];
    logic [63:0]     step_dist;
    logic [63:0]     moved;
    int              kept;
    int              fired;

    res.valve = '0;
    res.mask  = '0;
    res.last  = 1'b1;
    if (it.kind == KIND_ADD) begin
      if (slot_used >= TASK_SLOTS) begin
        // A full list refuses the task and consumes no id.
        res.kind = RES_FULL;
        res.id   = '0;
      end else begin
        slot_goal[slot_used]  = {8'd0, it.target_um} * UNITS_PER_UM;
        slot_moved[slot_used] = '0;
        slot_valve[slot_used] = it.valve_id;
        slot_mask[slot_used]  = it.valve_mask;
        slot_tag[slot_used]   = id_counter;
        slot_used++;
        res.kind = RES_ACCEPTED;
        res.id   = id_counter;
        id_counter = id_counter + 1'b1;
      end
      pending_results.push_back(res);
    end else if (it.elapsed_ms != '0) begin
      // Trapezoid distance in 1/120 um; a zero elapsed time leaves even the
      // remembered speed alone, so it never reaches this branch.
      step_dist = (64'(last_speed) + 64'(it.speed_mm_per_min)) * 64'(it.elapsed_ms);
      kept  = 0;
      fired = 0;
      for (int i = 0; i < slot_used; i++) begin
        moved = 64'(slot_moved[i]) + step_dist;
        if (moved > 64'h0000_0000_FFFF_FFFF) moved = 64'h0000_0000_FFFF_FFFF;
        if (moved >= 64'(slot_goal[i])) begin
          burst[fired].kind  = RES_FIRE;
          burst[fired].id    = slot_tag[i];
          burst[fired].valve = slot_valve[i];
          burst[fired].mask  = slot_mask[i];
          burst[fired].last  = 1'b0;
          fired++;
        end else begin
          slot_goal[kept]  = slot_goal[i];
          slot_moved[kept] = moved[DIST_W-1:0];
          slot_valve[kept] = slot_valve[i];
          slot_mask[kept]  = slot_mask[i];
          slot_tag[kept]   = slot_tag[i];
          kept++;
        end
      end
      slot_used  = kept;
      last_speed = it.speed_mm_per_min;
      if (fired > 0) burst[fired-1].last = 1'b1;
      for (int i = 0; i < fired; i++) pending_results.push_back(burst[i]);
    end
  endtask

  // Sender. An optional gap first, then the item is held on the channel until
  // it is accepted. Valid stays high on return so that back-to-back items do
  // not lower and raise it in the same time step.
  task automatic offer_item(input belt_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid            <= 1'b1;
    in_ch.kind             <= it.kind;
    in_ch.target_um        <= it.target_um;
    in_ch.valve_id         <= it.valve_id;
    in_ch.valve_mask       <= it.valve_mask;
    in_ch.speed_mm_per_min <= it.speed_mm_per_min;
    in_ch.elapsed_ms       <= it.elapsed_ms;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_item(it);
    items_sent++;
  endtask

  // Fields that an item's kind ignores still carry random bits.
  task automatic offer_add(input logic [TARGET_W-1:0] target, input logic [VALVE_W-1:0] valve,
                           input logic [MASK_W-1:0] mask);
    belt_item_t it;
    it.kind             = KIND_ADD;
    it.target_um        = target;
    it.valve_id         = valve;
    it.valve_mask       = mask;
    it.speed_mm_per_min = SPEED_W'($urandom);
    it.elapsed_ms       = MS_W'($urandom);
    offer_item(it);
  endtask

  task automatic offer_speed(input logic [SPEED_W-1:0] speed, input logic [MS_W-1:0] ms);
    belt_item_t it;
    it.kind             = KIND_SPEED;
    it.target_um        = TARGET_W'($urandom);
    it.valve_id         = VALVE_W'($urandom);
    it.valve_mask       = MASK_W'($urandom);
    it.speed_mm_per_min = speed;
    it.elapsed_ms       = ms;
    offer_item(it);
  endtask

  // Receiver. Ready drops for random stretches while pacing is on. A hold
  // request from a test turns into one long stall counted down right here.
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left == 0 && pacing_on && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Checker. Every accepted result is matched against the oldest prediction.
  always @(posedge clk) begin
    tracker_result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_seen++;
      if (out_ch.result_kind == RES_FIRE) fires_seen++;
      if (out_ch.result_kind == RES_FULL) full_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d id %0d", out_ch.result_kind,
                                  out_ch.task_id));
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", 32'(out_ch.result_kind), 32'(want.kind));
        check_field("task_id", 32'(out_ch.task_id), 32'(want.id));
        check_field("valve_id_res", 32'(out_ch.valve_id_res), 32'(want.valve));
        check_field("valve_mask_res", 32'(out_ch.valve_mask_res), 32'(want.mask));
        check_field("last", 32'(out_ch.last), 32'(want.last));
      end
    end
  end

  // Edge cases of single tasks: a zero target firing at zero speed, an update
  // with no elapsed time, an update that fires nothing, and the largest
  // target overtaken by a saturating distance at full speed and time.
  task automatic test_single_task_edges();
    offer_add('0, '0, '0);
    offer_speed('1, '0);
    offer_speed('0, MS_W'(1));
    offer_add('1, '1, '1);
    offer_speed(SPEED_W'(1), MS_W'(1));
    offer_speed('1, '1);
  endtask

  // Fill the list, bounce two adds off it, then fire all sixteen in order.
  task automatic test_table_full();
    for (int i = 0; i < TASK_SLOTS; i++) begin
      offer_add(TARGET_W'($urandom_range(1000, 16777215)), VALVE_W'($urandom),
                MASK_W'($urandom));
    end
    offer_add('0, '1, '1);
    offer_add('1, '0, '0);
    offer_speed('1, '1);
  endtask

  // The receiver stalls for a long stretch while the sender keeps going, so
  // the output register fills and the input stalls.
  task automatic test_output_backpressure();
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 12; i++) offer_add('0, VALVE_W'($urandom), MASK_W'($urandom));
    offer_speed(SPEED_W'($urandom_range(0, 1000)), MS_W'(1));
    for (int i = 0; i < 4; i++) offer_add(TARGET_W'($urandom_range(0, 50)), VALVE_W'($urandom),
                                          MASK_W'($urandom));
    offer_speed(SPEED_W'($urandom_range(0, 1000)), MS_W'(5));
  endtask

  // Realistic belt traffic: mostly moderate speeds, short intervals and
  // targets that fire after a handful of updates, so the list fills and
  // drains often. A tenth of the targets and speeds, and 8 in 100 elapsed times, span their full range.
  task automatic test_random_traffic();
    belt_item_t it;
    int         roll;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) pacing_on = ($urandom_range(0, 3) != 0);
      it.kind = ($urandom_range(0, 99) < 45) ? KIND_ADD : KIND_SPEED;
      it.target_um = ($urandom_range(0, 9) == 0) ? TARGET_W'($urandom)
                                                 : TARGET_W'($urandom_range(0, 150000));
      it.valve_id   = VALVE_W'($urandom);
      it.valve_mask = MASK_W'($urandom);
      it.speed_mm_per_min = ($urandom_range(0, 9) == 0) ? SPEED_W'($urandom)
                                                        : SPEED_W'($urandom_range(0, 90000));
      roll = $urandom_range(0, 99);
      if (roll < 6) it.elapsed_ms = '0;
      else if (roll < 14) it.elapsed_ms = MS_W'($urandom);
      else it.elapsed_ms = MS_W'($urandom_range(1, 40));
      offer_item(it);
    end
    pacing_on = 1'b1;
  endtask

  initial begin
    int waited;
    rst_n                  = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.kind             = KIND_ADD;
    in_ch.target_um        = '0;
    in_ch.valve_id         = '0;
    in_ch.valve_mask       = '0;
    in_ch.speed_mm_per_min = '0;
    in_ch.elapsed_ms       = '0;
    slot_used      = 0;
    id_counter     = '0;
    last_speed     = '0;
    mismatch_count = 0;
    items_sent     = 0;
    results_seen   = 0;
    fires_seen     = 0;
    full_seen      = 0;
    cycle_count    = 0;
    hold_request   = 0;
    pacing_on      = 1'b1;

    // Synchronous reset held from the start, then released once at a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_task_edges();
    test_table_full();
    test_output_backpressure();
    test_random_traffic();

    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Wait for every owed result, then a little longer to catch strays.
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", pending_results.size()));
    end

    $display("Run covered %0d items and %0d results: %0d valve fires, %0d table-full refusals.",
             items_sent, results_seen, fires_seen, full_seen);
    $display("A %0d-cycle output stall was included; %0d task ids were handed out.",
             HOLD_CYCLES, id_counter);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
